/* src/loas_latm_frame_packer_macros.svh */
// Assertion macros for the LOAS/LATM frame packer.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef LOAS_LATM_FRAME_PACKER_MACROS_SVH
`define LOAS_LATM_FRAME_PACKER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define LLFP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define LLFP_ASSERT_NEVER(label, cond, msg) \
  `LLFP_ASSERT_IMPL(label, 1'b1, !(cond), msg)

`endif

/* src/llfp_pkg.sv */
// Shared types and constants of the LOAS/LATM frame packer.
// Used by llfp_bit_packer and loas_latm_frame_packer; depends on nothing.
package llfp_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 8191;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MUX_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_AUDIO_BITS   = 2'd1;
  localparam logic [1:0] CFG_AUDIO_COUNT  = 2'd2;

  localparam logic [15:0] MUX_INTERVAL_RESET = 16'd20;

  // Frame constants; bit chunks are left aligned in a byte.
  localparam logic [7:0] SYNC_BYTE    = 8'h56;
  localparam logic [7:0] LEN_HI_BASE  = 8'he0;
  localparam logic [7:0] MUX_HDR_HI   = 8'h40;  // top 7 of the 15-bit 0x2000
  localparam logic [7:0] MUX_HDR_LO   = 8'h00;  // low 8 of the 15-bit 0x2000
  localparam logic [7:0] MUX_TAIL_HI  = 8'h1f;  // 3 zero bits, 5 of the 0xff
  localparam logic [7:0] MUX_TAIL_LO  = 8'he0;  // last 3 of the 0xff, 2 zeros
  localparam logic [7:0] ESC_BYTE     = 8'hff;
  localparam logic [7:0] ADTS_SYNC    = 8'hff;
  localparam logic [3:0] ADTS_NIBBLE  = 4'hf;

  // One chunk of up to eight bits for the bit packer.
  typedef struct packed {
    logic       en;
    logic       clr;
    logic [7:0] data;   // left aligned, unused low bits zero
    logic [3:0] count;  // 1 to 8
  } llfp_pk_cmd_t;

  typedef struct packed {
    logic [7:0] res;    // residue bits, left aligned, zero padded
    logic [2:0] rc;     // residue bit count
    logic       emit;   // the current chunk completes a byte
    logic [7:0] obyte;  // that byte
  } llfp_pk_stat_t;

endpackage

/* src/llfp_bit_packer.sv */
// Shared bit packer: merges a chunk of up to eight bits into the residue.
// Depends on llfp_pkg for the command and status structs.
module llfp_bit_packer
  import llfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  llfp_pk_cmd_t  cmd,
  output llfp_pk_stat_t stat
);

  logic [7:0]  res;
  logic [2:0]  rc;
  logic [15:0] window;
  logic [3:0]  total;

  always_comb begin
    window     = {res, 8'h00} | ({cmd.data, 8'h00} >> rc);
    total      = {1'b0, rc} + cmd.count;
    stat.res   = res;
    stat.rc    = rc;
    stat.emit  = total[3];
    stat.obyte = window[15:8];
  end

  // When a byte completes, the bits below it become the new residue.
  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
      rc  <= '0;
    end else if (cmd.clr) begin
      res <= '0;
      rc  <= '0;
    end else if (cmd.en) begin
      res <= total[3] ? window[7:0] : window[15:8];
      rc  <= total[2:0];
    end
  end

endmodule

/* src/loas_latm_frame_packer.sv */
// LOAS/LATM frame packer: a first byte is held, a middle payload byte is packed in S_BYTE,
// a frame header runs through prepare, align, three sync bytes and its bit chunks, and a
// mux counter wrap adds a serial remainder. The shared bit packer takes one chunk per cycle
// when the output is free. New bytes wait until the last is packed; output is registered.
// Reset is synchronous, active high: sequencer, counters and output valid clear, and the
// configuration registers return to interval 20 and an empty AudioSpecificConfig.
`include "loas_latm_frame_packer_macros.svh"

module loas_latm_frame_packer
  import llfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // [7:0] data_byte, [20:8] packet_length, [23:21] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] out_byte
  output logic        m_tlast,    // frame_end
  output logic        m_tuser,    // status: 1 marks an ADTS rejection beat
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // The sequencer walks the frame one chunk at a time. Each chunk state feeds
  // the shared bit packer and waits while the output register is occupied.
  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_REJECT = 20'h00002,
    S_PREP   = 20'h00004,
    S_ALIGN  = 20'h00008,
    S_SYNC0  = 20'h00010,
    S_SYNC1  = 20'h00020,
    S_SYNC2  = 20'h00040,
    S_USE    = 20'h00080,
    S_M15A   = 20'h00100,
    S_M15B   = 20'h00200,
    S_CFG    = 20'h00400,
    S_TAIL8  = 20'h00800,
    S_TAIL5  = 20'h01000,
    S_ESC    = 20'h02000,
    S_REM    = 20'h04000,
    S_HELD   = 20'h08000,
    S_BYTE   = 20'h10000,
    S_FLUSH  = 20'h20000,
    S_MODI   = 20'h40000,
    S_MOD    = 20'h80000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [15:0] mux_interval;
  logic [63:0] acfg_bits;
  logic [6:0]  acfg_count;

  // Packet state.
  logic [15:0] mux_counter;
  logic [12:0] pos;
  logic [7:0]  held;
  logic        drop_pkt;

  // Item and header working registers.
  logic [7:0]  b_r;
  logic [12:0] len_r;
  logic        last_r;
  logic        hdr_r;
  logic        with_held;
  logic        mux0;
  logic [5:0]  q_r;
  logic [7:0]  rem_r;
  logic [5:0]  esc;
  logic [12:0] flen_r;
  logic [63:0] sh;
  logic [6:0]  pad;
  logic [6:0]  k;

  // Counter wrap: serial restoring remainder.
  logic [16:0] modx;
  logic [15:0] remr;
  logic [4:0]  mi;

  // Output register.
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_user;
  logic       load_out;
  logic [7:0] out_byte_next;
  logic       out_last_next;
  logic       out_user_next;
  logic       out_free;

  llfp_pk_cmd_t  pk_cmd;
  llfp_pk_stat_t pk_stat;

  // Combinational helpers.
  logic        s_acc;
  logic [7:0]  b_in;
  logic [12:0] len_in;
  logic [12:0] len_clamp;
  logic        last_in;
  logic        reject_in;
  logic [6:0]  n_sat;
  logic [13:0] qsum;
  logic [5:0]  q_calc;
  logic [13:0] rem_calc;
  logic [6:0]  q1;
  logic [17:0] bits_calc;
  logic [17:0] flen_sum;
  logic [15:0] mod_m;
  logic [16:0] mod_m17;
  logic [16:0] mod_x;
  logic [16:0] trial;
  logic [16:0] trial_res;
  logic        chunk;
  logic        chunk_last;
  state_t      chunk_next;
  logic [3:0]  cfg_chunk;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = out_user;

  llfp_bit_packer u_packer (
    .clk  (clk),
    .rst  (rst),
    .cmd  (pk_cmd),
    .stat (pk_stat)
  );

  always_comb begin
    b_in   = s_tdata[7:0];
    len_in = s_tdata[20:8];
    if (len_in == 13'd0) begin
      len_clamp = 13'd1;
    end else if (len_in > 13'(MAX_PACKET_BYTES)) begin
      len_clamp = 13'(MAX_PACKET_BYTES);
    end else begin
      len_clamp = len_in;
    end
    last_in   = ({1'b0, pos} + 14'd1) >= {1'b0, len_clamp};
    // An ADTS sync at the head of a packet longer than two bytes is refused.
    reject_in = (len_clamp > 13'd2) && (held == ADTS_SYNC) && (b_in[7:4] == ADTS_NIBBLE);
    n_sat     = (acfg_count > 7'd64) ? 7'd64 : acfg_count;

    // Length divided by 255 through the reciprocal identity, exact below 65535.
    qsum     = {1'b0, len_r} + {9'b0, len_r[12:8]} + 14'd1;
    q_calc   = qsum[13:8];
    rem_calc = {1'b0, len_r} - {q_calc, 8'h00} + {8'b0, q_calc};

    // Frame length in bytes of the bit stream that follows the three header bytes.
    q1        = {1'b0, q_r} + 7'd1;
    bits_calc = 18'd1 + {8'b0, q1, 3'b000} + {2'b0, len_r, 3'b000}
              + (mux0 ? (18'd28 + {11'b0, n_sat}) : 18'd0);
    flen_sum  = bits_calc + 18'd7;

    mod_m     = (mux_interval == 16'd0) ? 16'd1 : mux_interval;
    mod_m17   = {1'b0, mod_m};
    mod_x     = {1'b0, mux_counter} + 17'd1;
    trial     = {remr, modx[mi]};
    trial_res = (trial >= mod_m17) ? (trial - mod_m17) : trial;
    cfg_chunk = (k >= 7'd8) ? 4'd8 : k[3:0];
  end

  // Sequencer and chunk selection.
  always_comb begin
    state_next    = state;
    pk_cmd        = '0;
    load_out      = 1'b0;
    out_byte_next = 8'h00;
    out_last_next = 1'b0;
    out_user_next = 1'b0;
    chunk         = 1'b0;
    chunk_last    = 1'b0;
    chunk_next    = state;

    case (state)
      S_IDLE: begin
        if (s_acc) begin
          if (drop_pkt) begin
            state_next = S_IDLE;
          end else if (pos == 13'd0) begin
            state_next = last_in ? S_PREP : S_IDLE;
          end else if (pos == 13'd1) begin
            state_next = reject_in ? S_REJECT : S_PREP;
          end else begin
            state_next = S_BYTE;
          end
        end
      end
      S_REJECT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_user_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_PREP: begin
        pk_cmd.clr = 1'b1;
        state_next = S_ALIGN;
      end
      S_ALIGN: begin
        if (pad == 7'd0) begin
          state_next = S_SYNC0;
        end
      end
      S_SYNC0: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_byte_next = SYNC_BYTE;
          state_next    = S_SYNC1;
        end
      end
      S_SYNC1: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_byte_next = LEN_HI_BASE | {3'b000, flen_r[12:8]};
          state_next    = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_byte_next = flen_r[7:0];
          state_next    = S_USE;
        end
      end
      S_USE: begin
        chunk        = 1'b1;
        pk_cmd.data  = {!mux0, 7'b0000000};
        pk_cmd.count = 4'd1;
        chunk_next   = mux0 ? S_M15A : ((esc != 6'd0) ? S_ESC : S_REM);
      end
      S_M15A: begin
        chunk        = 1'b1;
        pk_cmd.data  = MUX_HDR_HI;
        pk_cmd.count = 4'd7;
        chunk_next   = S_M15B;
      end
      S_M15B: begin
        chunk        = 1'b1;
        pk_cmd.data  = MUX_HDR_LO;
        pk_cmd.count = 4'd8;
        chunk_next   = (k != 7'd0) ? S_CFG : S_TAIL8;
      end
      S_CFG: begin
        chunk        = 1'b1;
        pk_cmd.data  = sh[63:56];
        pk_cmd.count = cfg_chunk;
        chunk_next   = (k == {3'b000, cfg_chunk}) ? S_TAIL8 : S_CFG;
      end
      S_TAIL8: begin
        chunk        = 1'b1;
        pk_cmd.data  = MUX_TAIL_HI;
        pk_cmd.count = 4'd8;
        chunk_next   = S_TAIL5;
      end
      S_TAIL5: begin
        chunk        = 1'b1;
        pk_cmd.data  = MUX_TAIL_LO;
        pk_cmd.count = 4'd5;
        chunk_next   = (esc != 6'd0) ? S_ESC : S_REM;
      end
      S_ESC: begin
        chunk        = 1'b1;
        pk_cmd.data  = ESC_BYTE;
        pk_cmd.count = 4'd8;
        chunk_next   = (esc == 6'd1) ? S_REM : S_ESC;
      end
      S_REM: begin
        chunk        = 1'b1;
        pk_cmd.data  = rem_r;
        pk_cmd.count = 4'd8;
        chunk_next   = with_held ? S_HELD : S_BYTE;
      end
      S_HELD: begin
        chunk        = 1'b1;
        pk_cmd.data  = held;
        pk_cmd.count = 4'd8;
        chunk_next   = S_BYTE;
      end
      S_BYTE: begin
        chunk        = 1'b1;
        pk_cmd.data  = b_r;
        pk_cmd.count = 4'd8;
        chunk_last   = last_r && (pk_stat.rc == 3'd0);
        if (last_r && (pk_stat.rc != 3'd0)) begin
          chunk_next = S_FLUSH;
        end else begin
          chunk_next = hdr_r ? S_MODI : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_byte_next = pk_stat.res;
          out_last_next = 1'b1;
          pk_cmd.clr    = 1'b1;
          state_next    = hdr_r ? S_MODI : S_IDLE;
        end
      end
      S_MODI: begin
        state_next = (mod_x < mod_m17) ? S_IDLE : S_MOD;
      end
      S_MOD: begin
        if (mi == 5'd0) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (chunk && out_free) begin
      pk_cmd.en     = 1'b1;
      state_next    = chunk_next;
      load_out      = pk_stat.emit;
      out_byte_next = pk_stat.obyte;
      out_last_next = chunk_last;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      mux_interval <= MUX_INTERVAL_RESET;
      acfg_bits    <= '0;
      acfg_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MUX_INTERVAL: mux_interval <= cfg_data[15:0];
        CFG_AUDIO_BITS:   acfg_bits    <= cfg_data;
        CFG_AUDIO_COUNT:  acfg_count   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Packet control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mux_counter <= '0;
      pos         <= '0;
      held        <= '0;
      drop_pkt    <= 1'b0;
      last_r      <= 1'b0;
      hdr_r       <= 1'b0;
      with_held   <= 1'b0;
      mux0        <= 1'b0;
      esc         <= '0;
      pad         <= '0;
      k           <= '0;
      mi          <= '0;
    end else begin
      state <= state_next;
      if (s_acc) begin
        last_r    <= last_in;
        pos       <= last_in ? 13'd0 : (pos + 13'd1);
        hdr_r     <= !drop_pkt && (((pos == 13'd0) && last_in) ||
                                   ((pos == 13'd1) && !reject_in));
        with_held <= (pos == 13'd1);
        if (last_in) begin
          drop_pkt <= 1'b0;
        end else if (!drop_pkt && (pos == 13'd1) && reject_in) begin
          drop_pkt <= 1'b1;
        end
        if (!drop_pkt && (pos == 13'd0)) begin
          held <= b_in;
        end
      end
      if (state == S_PREP) begin
        mux0 <= (mux_counter == 16'd0);
        esc  <= q_calc;
        pad  <= 7'd64 - n_sat;
        k    <= n_sat;
      end
      if ((state == S_ALIGN) && (pad != 7'd0)) begin
        pad <= (pad >= 7'd8) ? (pad - 7'd8) : 7'd0;
      end
      if ((state == S_CFG) && out_free) begin
        k <= k - {3'b000, cfg_chunk};
      end
      if ((state == S_ESC) && out_free) begin
        esc <= esc - 6'd1;
      end
      if (state == S_MODI) begin
        if (mod_x < mod_m17) begin
          mux_counter <= mod_x[15:0];
        end
        mi <= 5'd16;
      end
      if (state == S_MOD) begin
        if (mi == 5'd0) begin
          mux_counter <= trial_res[15:0];
        end else begin
          mi <= mi - 5'd1;
        end
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      b_r   <= b_in;
      len_r <= len_clamp;
    end
    if (state == S_PREP) begin
      q_r   <= q_calc;
      rem_r <= rem_calc[7:0];
      sh    <= acfg_bits;
    end
    if ((state == S_ALIGN) && (pad != 7'd0)) begin
      // Left align the AudioSpecificConfig bits, a byte at a time, then the rest.
      sh <= (pad >= 7'd8) ? (sh << 8) : (sh << pad[2:0]);
    end
    if ((state == S_SYNC0) && out_free) begin
      flen_r <= flen_sum[15:3];
    end
    if ((state == S_CFG) && out_free) begin
      sh <= sh << 8;
    end
    if (state == S_MODI) begin
      modx <= mod_x;
      remr <= '0;
    end
    if (state == S_MOD) begin
      remr <= trial_res[15:0];
    end
  end

  // Output register: a new beat loads while the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte <= out_byte_next;
      out_last <= out_last_next;
      out_user <= out_user_next;
    end
  end

  `LLFP_ASSERT_IMPL(a_drop_pos, drop_pkt, pos >= 13'd2, "packet drop below position two")
  `LLFP_ASSERT_IMPL(a_flush_rc, state == S_FLUSH, pk_stat.rc != 3'd0, "flush with no residue")
  `LLFP_ASSERT_IMPL(a_reject_beat, m_tvalid && m_tuser, !m_tlast && (m_tdata == 8'h00), "bad reject beat")
  `LLFP_ASSERT_NEVER(a_esc_count, (state == S_ESC) && (esc == 6'd0), "escape state with none left")

endmodule
